/* sv/tdm_pkg.sv */
// Shared types and constants of the tile deduplication mapper.
`timescale 1ns / 1ps
`default_nettype none

package tdm_pkg;

  // Width and reset value of the rows-per-tile register.
  localparam int unsigned TILE_ROWS_W = 4;
  localparam logic [TILE_ROWS_W-1:0] TILE_ROWS_RST = 4'd8;

  // Width of the tile index in the map entry on the output stream.
  localparam int unsigned IDX_OUT_W = 8;

  // States of the matcher sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } tdm_state_e;

  // One map entry handed to the output stream.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] tile_index;
    logic                 is_new;
    logic                 store_full;
  } tdm_result_t;

endpackage

`default_nettype wire

/* sv/tdm_front.sv */
// Row collector: gathers the rows of one tile and queues finished tiles and clears.
`timescale 1ns / 1ps
`default_nettype none

module tdm_front #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned ROW_BITS = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [tdm_pkg::TILE_ROWS_W-1:0]       tile_rows_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [63:0]                           row_bits_i,
  input  wire logic                                  start_image_i,
  input  wire logic                                  q_full_i,
  output logic                                       q_push_o,
  // Queue entry: tile rows (row 0 lowest), has-tile flag, clear flag.
  output logic [MAX_ROWS*ROW_BITS+1:0]               q_data_o
);
  import tdm_pkg::*;

  localparam int unsigned RC_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned TILE_W = MAX_ROWS * ROW_BITS;

  logic [ROW_BITS-1:0] pend_q [MAX_ROWS];
  logic [RC_W-1:0]     row_cnt_q, row_cnt_d;
  logic [RC_W-1:0]     base_cnt;
  logic [RC_W:0]       next_cnt;
  logic [RC_W-1:0]     rows_eff;
  logic [TILE_W-1:0]   tile;
  logic                accept;
  logic                done;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Effective tile height: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (tile_rows_i == '0) begin
      rows_eff = RC_W'(1);
    end else if (32'(tile_rows_i) > MAX_ROWS) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = RC_W'(tile_rows_i);
    end
  end

  // Row slot for this item; a start flag drops the partial tile.
  always_comb begin
    if (start_image_i || (32'(row_cnt_q) >= MAX_ROWS)) begin
      base_cnt = '0;
    end else begin
      base_cnt = row_cnt_q;
    end
    next_cnt = {1'b0, base_cnt} + (RC_W + 1)'(1);
    done     = next_cnt >= {1'b0, rows_eff};
  end

  // Finished tile: stored rows, this row, and zeros past the height.
  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      if (RC_W'(r) < base_cnt) begin
        tile[r*ROW_BITS +: ROW_BITS] = pend_q[r];
      end else if (RC_W'(r) == base_cnt) begin
        tile[r*ROW_BITS +: ROW_BITS] = row_bits_i[ROW_BITS-1:0];
      end else begin
        tile[r*ROW_BITS +: ROW_BITS] = '0;
      end
    end
  end

  assign q_push_o = accept && (done || start_image_i);
  assign q_data_o = {start_image_i, done, tile};

  always_comb begin
    row_cnt_d = row_cnt_q;
    if (accept) begin
      row_cnt_d = done ? '0 : next_cnt[RC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
    end
  end

  // Pending rows hold payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q[base_cnt[RI_W-1:0]] <= row_bits_i[ROW_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/tdm_queue.sv */
// Short first-in first-out queue between the row collector and the matcher.
`timescale 1ns / 1ps
`default_nettype none

module tdm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);
  import tdm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = 32'(cnt_q) == DEPTH;
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/tdm_back.sv */
// Matcher: searches the unique tile store one entry a cycle and stores new tiles.
`timescale 1ns / 1ps
`default_nettype none

module tdm_back #(
  parameter int unsigned MAX_TILES = 256,
  parameter int unsigned TILE_W    = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output logic                    q_pop_o,
  // Queue entry: tile rows (row 0 lowest), has-tile flag, clear flag.
  input  wire logic [TILE_W+1:0]  q_data_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output tdm_pkg::tdm_result_t    res_o
);
  import tdm_pkg::*;

  localparam int unsigned IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TILES + 1);

  logic [TILE_W-1:0] store_mem [MAX_TILES];
  logic [TILE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_addr;

  tdm_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              res_new_q, res_new_d;
  logic              res_full_q, res_full_d;
  logic [TILE_W-1:0] tile_q;
  logic              tile_load;
  logic              mem_we;
  logic              out_load;
  logic              out_valid_q;
  tdm_result_t       out_q;
  logic [CNT_W-1:0]  base_cnt;
  logic [31:0]       idx_wide;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign idx_wide    = 32'(res_idx_q);

  // Sequencer: take a queue entry, walk the store, then hand over the map entry; a clear-only entry yields none.
  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    rd_addr    = idx_q + IDX_W'(1);
    res_idx_d  = res_idx_q;
    res_new_d  = res_new_q;
    res_full_d = res_full_q;
    tile_load  = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    base_cnt   = q_data_i[TILE_W+1] ? '0 : cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cnt_d   = base_cnt;
          if (q_data_i[TILE_W]) begin
            tile_load = 1'b1;
            idx_d     = '0;
            rd_addr   = '0;
            if (base_cnt == '0) begin
              // Empty store: the tile goes straight in at index zero.
              res_idx_d  = '0;
              res_new_d  = 1'b1;
              res_full_d = 1'b0;
              state_d    = ST_EMIT;
            end else begin
              state_d = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (rd_data_q == tile_q) begin
          res_idx_d  = idx_q;
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
          state_d    = ST_EMIT;
        end else if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
          // Last stored tile missed: add the tile, or report a full store.
          if (32'(cnt_q) >= MAX_TILES) begin
            res_idx_d  = '0;
            res_new_d  = 1'b0;
            res_full_d = 1'b1;
          end else begin
            res_idx_d  = cnt_q[IDX_W-1:0];
            res_new_d  = 1'b1;
            res_full_d = 1'b0;
          end
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          if (res_new_q) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search index, result and tile registers carry payload only.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
    if (tile_load) begin
      tile_q <= q_data_i[TILE_W-1:0];
    end
    if (out_load) begin
      out_q.tile_index <= idx_wide[IDX_OUT_W-1:0];
      out_q.is_new     <= res_new_q;
      out_q.store_full <= res_full_q;
    end
  end

  // Unique tile store: one whole tile per entry, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[res_idx_q] <= tile_q;
    end
    rd_data_q <= store_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/tile_dedup_mapper_core.sv */
// A finished tile passes through the queue, the store search and the output register.
// Rows are taken one a cycle while collecting and the queue is not full; the matcher takes
// one tile at a time and walks the store through its one-entry-a-cycle read port, while the
// queue holds further tiles.
// Reset empties the store (count cleared) and sets 8 rows per tile; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tile_dedup_mapper_core #(
  parameter int unsigned MAX_TILES   = 256,
  parameter int unsigned MAX_ROWS    = 8,
  parameter int unsigned ROW_BITS    = 64,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [63:0]                       s_axis_tdata,   // row_bits
  input  wire logic [0:0]                        s_axis_tuser,   // start_image
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [7:0]                             m_axis_tdata,   // tile_index
  output logic [1:0]                             m_axis_tuser,   // is_new, store_full
  input  wire logic                              cfg_we_i,
  input  wire logic [tdm_pkg::TILE_ROWS_W-1:0]   cfg_wdata_i
);
  import tdm_pkg::*;

  localparam int unsigned TILE_W  = MAX_ROWS * ROW_BITS;
  localparam int unsigned ENTRY_W = TILE_W + 2;

  logic [TILE_ROWS_W-1:0] tile_rows_q;
  logic                   q_full, q_push, q_valid, q_pop;
  logic [ENTRY_W-1:0]     q_wdata, q_rdata;
  tdm_result_t            res;

  // Rows-per-tile register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_rows_q <= TILE_ROWS_RST;
    end else if (cfg_we_i) begin
      tile_rows_q <= cfg_wdata_i;
    end
  end

  tdm_front #(
    .MAX_ROWS (MAX_ROWS),
    .ROW_BITS (ROW_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tile_rows_i   (tile_rows_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .row_bits_i    (s_axis_tdata),
    .start_image_i (s_axis_tuser[0]),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  tdm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  tdm_back #(
    .MAX_TILES (MAX_TILES),
    .TILE_W    (TILE_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_rdata),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.tile_index;
  assign m_axis_tuser = {res.store_full, res.is_new};

  // A full-store report carries index zero and never marks a new tile.
  a_full_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == 8'd0) && !m_axis_tuser[0])
    else $error("store-full result with non-zero index or new flag");

  // A tile is either added or reported as not fitting, never both.
  a_new_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both new and store full");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the tile deduplication mapper, with its own prediction of the map entries.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import tdm_pkg::*;

  localparam int unsigned MAX_TILES     = 256;
  localparam int unsigned MAX_ROWS      = 8;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned FULL_ITEMS    = 290;

  // One row waiting to be offered, packed as it goes onto the input stream.
  typedef struct packed {
    logic [63:0] row;
    logic        start;
  } row_item_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [63:0]            s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [TILE_ROWS_W-1:0] cfg_wdata_i   = '0;

  // Stimulus and expectation stores.
  row_item_t   rows_to_send [$];
  tdm_result_t expected_map_entries [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  logic        in_hs        = 1'b0;
  logic        steady_sender = 1'b0;

  // Predictor state.
  logic [TILE_ROWS_W-1:0] model_rows = TILE_ROWS_RST;
  logic [63:0]            tile_rows_buf [MAX_ROWS];
  logic [63:0]            tile_store [MAX_TILES][MAX_ROWS];
  int unsigned            rows_held    = 0;
  int unsigned            stored_tiles = 0;

  // Sender and receiver pacing.
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned rx_mode        = 0;
  int unsigned rx_mode_left   = 0;
  int unsigned rx_tick        = 0;
  int unsigned long_hold_left = 0;
  logic        long_hold_done = 1'b0;

  tile_dedup_mapper_core #(
    .MAX_TILES (MAX_TILES),
    .MAX_ROWS  (MAX_ROWS),
    .ROW_BITS  (64)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Free-running clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run length.
  initial begin
    #10ms;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Takes one accepted row and, when it completes a tile, works out its map entry.
  task automatic predict_tile_map(input logic [63:0] row, input logic start);
    int unsigned height;
    int unsigned hit;
    int unsigned i;
    int unsigned r;
    logic        same;
    tdm_result_t entry;
    height = (model_rows == 0) ? 1 : ((model_rows > MAX_ROWS) ? MAX_ROWS : model_rows);
    if (start) begin
      stored_tiles = 0;
      rows_held    = 0;
    end
    if (rows_held >= MAX_ROWS) rows_held = 0;
    tile_rows_buf[rows_held] = row;
    rows_held++;
    if (rows_held < height) return;
    // Rows past the tile height are kept as zero so that all rows take part in matching.
    for (r = rows_held; r < MAX_ROWS; r++) tile_rows_buf[r] = '0;
    rows_held = 0;
    hit = stored_tiles;
    for (i = 0; i < stored_tiles && hit == stored_tiles; i++) begin
      same = 1'b1;
      for (r = 0; r < MAX_ROWS; r++) begin
        if (tile_store[i][r] != tile_rows_buf[r]) same = 1'b0;
      end
      if (same) hit = i;
    end
    if (hit < stored_tiles) begin
      entry = '{tile_index: hit[7:0], is_new: 1'b0, store_full: 1'b0};
    end else if (stored_tiles >= MAX_TILES) begin
      entry = '{tile_index: 8'd0, is_new: 1'b0, store_full: 1'b1};
    end else begin
      for (r = 0; r < MAX_ROWS; r++) tile_store[stored_tiles][r] = tile_rows_buf[r];
      entry = '{tile_index: stored_tiles[7:0], is_new: 1'b1, store_full: 1'b0};
      stored_tiles++;
    end
    expected_map_entries.push_back(entry);
  endtask

  // Input and output monitor: predicts on accepted rows and checks accepted map entries.
  always @(posedge clk_i) begin
    tdm_result_t want;
    in_hs = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) model_rows = cfg_wdata_i;
      if (in_hs) predict_tile_map(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_map_entries.size() == 0) begin
          report_mismatch($sformatf("map entry %0d with none expected", m_axis_tdata));
        end else begin
          want = expected_map_entries.pop_front();
          if (m_axis_tdata != want.tile_index)
            report_mismatch($sformatf("tile_index %0d, expected %0d",
                                      m_axis_tdata, want.tile_index));
          if (m_axis_tuser[0] != want.is_new)
            report_mismatch($sformatf("is_new %0b, expected %0b",
                                      m_axis_tuser[0], want.is_new));
          if (m_axis_tuser[1] != want.store_full)
            report_mismatch($sformatf("store_full %0b, expected %0b",
                                      m_axis_tuser[1], want.store_full));
        end
      end
    end
  end

  // Row driver: offers queued rows in bursts, with random gaps between bursts unless steady_sender is set.
  always @(negedge clk_i) begin
    logic offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (in_hs) begin
        void'(rows_to_send.pop_front());
        if (burst_left != 0) burst_left--;
        if (burst_left == 0 && !steady_sender)
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
      if (s_axis_tvalid && !in_hs) begin
        offer = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (rows_to_send.size() != 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        offer = 1'b1;
      end
      s_axis_tvalid <= offer;
      if (offer) {s_axis_tdata, s_axis_tuser} <= rows_to_send[0];
    end
  end

  // Receiver: stalls on a pattern of changing modes, plus one long hold-off.
  always @(negedge clk_i) begin
    rx_tick++;
    if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      m_axis_tready  <= 1'b0;
    end else if (!long_hold_done && results_seen >= 60) begin
      long_hold_done <= 1'b1;
      long_hold_left <= 800;
      m_axis_tready  <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(32, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= $urandom_range(0, 1);
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_axis_tready <= ((rx_tick % 5) < 3);
        end
      endcase
    end
  end

  function automatic logic [63:0] random_row();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_row(input logic [63:0] row, input logic start);
    rows_to_send.push_back('{row: row, start: start});
  endtask

  // Waits until every row is taken and every map entry has come, then lets the matcher settle.
  task automatic wait_quiet();
    while (rows_to_send.size() != 0 || s_axis_tvalid || expected_map_entries.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_tile_rows(input logic [TILE_ROWS_W-1:0] value);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus: directed rows, random phases over several tile heights, then a full store.
  initial begin
    int unsigned            phase_rows [9];
    logic [63:0]            tile_pool [16][8];
    logic [63:0]            full_vals [FULL_ITEMS];
    logic [63:0]            row;
    int unsigned            k;
    int unsigned            n;
    int unsigned            p;
    int unsigned            r;
    int unsigned            kind;
    int unsigned            height;
    int unsigned            flip;
    int unsigned            flip_row;
    logic                   tile_start;

    phase_rows = '{1, 8, 3, 15, 0, 2, 5, 8, 4};
    foreach (tile_pool[i, j]) tile_pool[i][j] = random_row();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Eight-row tile at the reset height, with the extremes of the row word.
    push_row('1, 1'b1);
    push_row('0, 1'b0);
    push_row(64'd1, 1'b0);
    push_row(64'h8000_0000_0000_0000, 1'b0);
    for (r = 0; r < 4; r++) push_row(random_row(), 1'b0);
    // A partial tile, then the height drops below the rows already held.
    for (r = 0; r < 3; r++) push_row(random_row(), 1'b0);
    set_tile_rows(4'd2);
    push_row('1, 1'b0);
    // Short tile equal to the head of the first one; the zero rows keep them apart.
    push_row('1, 1'b0);
    push_row('0, 1'b0);
    push_row('1, 1'b0);
    push_row('0, 1'b0);
    // Height of zero acts as one row.
    set_tile_rows(4'd0);
    push_row('0, 1'b0);
    push_row('0, 1'b0);
    push_row('1, 1'b1);
    // Height above the maximum acts as eight; the start flag drops the partial tile.
    set_tile_rows(4'd15);
    push_row(random_row(), 1'b0);
    push_row('1, 1'b1);
    for (r = 0; r < 7; r++) push_row(random_row(), 1'b0);

    // Random phases: mostly repeated pool tiles so that matches are common.
    for (k = 0; k < 9; k++) begin
      set_tile_rows(phase_rows[k][TILE_ROWS_W-1:0]);
      height = (phase_rows[k] == 0) ? 1 : ((phase_rows[k] > MAX_ROWS) ? MAX_ROWS : phase_rows[k]);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (r = 0; r < 4; r++) begin
        p = $urandom_range(0, 15);
        for (int j = 0; j < MAX_ROWS; j++) tile_pool[p][j] = random_row();
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind       = $urandom_range(0, 99);
        p          = $urandom_range(0, 15);
        tile_start = ($urandom_range(0, 29) == 0);
        flip       = $urandom_range(0, 63);
        flip_row   = $urandom_range(0, height - 1);
        for (r = 0; r < height; r++) begin
          if (kind < 65) row = tile_pool[p][r];
          else if (kind < 85) row = random_row();
          else row = tile_pool[p][r] ^ ((r == flip_row) ? (64'd1 << flip) : 64'd0);
          // A stray start flag inside a tile breaks the sequence now and then.
          push_row(row, (r == 0) ? tile_start : ($urandom_range(0, 99) == 0));
          n++;
        end
      end
    end

    // Fill the store with distinct one-row tiles, overflow it, then match into it.
    set_tile_rows(4'd1);
    steady_sender = 1'b0;
    for (n = 0; n < FULL_ITEMS; n++) begin
      full_vals[n] = {$urandom, 16'($urandom), 16'(n)};
      push_row(full_vals[n], n == 0);
    end
    push_row(full_vals[0], 1'b0);
    push_row(full_vals[255], 1'b0);
    push_row(full_vals[256], 1'b0);
    push_row(full_vals[17], 1'b0);
    push_row(random_row(), 1'b0);
    push_row(full_vals[200], 1'b0);
    push_row(full_vals[289], 1'b1);
    push_row(full_vals[289], 1'b0);

    wait_quiet();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/tdm_pkg.sv
sv/tdm_front.sv
sv/tdm_queue.sv
sv/tdm_back.sv
sv/tile_dedup_mapper_core.sv
test/testbench.sv
